// File: hw/rtl/qtpu_pkg.sv
// ----------------------------------------------------------------------------
// qtpu_pkg: shared types and constants of the probability update unit
// Holds the transaction structs, the function codes and the fixed-point
// constants used by the lanes, the tracker and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package qtpu_pkg;

	localparam int PROB_W  = 17;
	localparam int THETA_W = 12;
	localparam int BITS_W  = 32;
	localparam int FIT_W   = 32;
	localparam int GEN_W   = 16;

	localparam logic [PROB_W-1:0]   PROB_HALF = 17'd32768;
	localparam logic [PROB_W-1:0]   PROB_ONE  = 17'd65536;
	localparam logic [THETA_W-1:0]  ROT_RESET = 12'd26;
	localparam logic signed [FIT_W-1:0] FIT_MAX = 32'sh7FFF_FFFF;

	typedef enum logic [1:0] {
		FUNC_SAMPLE = 2'd0,
		FUNC_EVAL   = 2'd1,
		FUNC_END_GEN = 2'd2,
		FUNC_NOP    = 2'd3
	} func_t;

	typedef struct packed {
		func_t                    func;
		logic [4:0]               item_index;
		logic [15:0]              random_fraction;
		logic [BITS_W-1:0]        candidate_bits;
		logic signed [FIT_W-1:0]  candidate_fitness;
	} req_t;

	typedef struct packed {
		logic                     sample_bit;
		logic [BITS_W-1:0]        best_bits;
		logic signed [FIT_W-1:0]  best_score;
		logic [GEN_W-1:0]         best_round;
		logic                     improved;
	} rsp_t;

	typedef struct packed {
		logic [BITS_W-1:0]        best_bits_nxt;
		logic signed [FIT_W-1:0]  best_score_nxt;
		logic [GEN_W-1:0]         best_round_nxt;
		logic                     improved;
		logic [BITS_W-1:0]        best_bits;
		logic [BITS_W-1:0]        worst_bits;
	} track_t;

endpackage

`default_nettype wire

// File: hw/rtl/qtpu_lane.sv
// ----------------------------------------------------------------------------
// qtpu_lane: one probability entry with its rotation update
// Holds a Q1.16 probability and applies the not-gate rotation toward the
// best bit and away from the worst bit, saturating at zero and one.
// ----------------------------------------------------------------------------
`default_nettype none

module qtpu_lane (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                upd_en,
	input  wire logic [qtpu_pkg::THETA_W-1:0]        theta,
	input  wire logic                                best_bit,
	input  wire logic                                worst_bit,
	output logic [qtpu_pkg::PROB_W-1:0]              prob
);

	logic [qtpu_pkg::PROB_W-1:0] prob_q;
	logic [qtpu_pkg::PROB_W-1:0] mirr;
	logic [qtpu_pkg::PROB_W-1:0] sum;
	logic [qtpu_pkg::PROB_W-1:0] prob_nxt;
	logic [qtpu_pkg::PROB_W-1:0] theta_x;

	assign theta_x = qtpu_pkg::PROB_W'(theta);

	always_comb begin
		mirr     = prob_q;
		sum      = prob_q;
		prob_nxt = prob_q;
		case ({best_bit, worst_bit})
			2'b01: begin
				mirr = (prob_q > qtpu_pkg::PROB_HALF) ? qtpu_pkg::PROB_ONE - prob_q : prob_q;
				prob_nxt = (mirr > theta_x) ? mirr - theta_x : '0;
			end
			2'b10: begin
				mirr = (prob_q < qtpu_pkg::PROB_HALF) ? qtpu_pkg::PROB_ONE - prob_q : prob_q;
				sum = mirr + theta_x;
				prob_nxt = (sum > qtpu_pkg::PROB_ONE) ? qtpu_pkg::PROB_ONE : sum;
			end
			default: begin
				prob_nxt = prob_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prob_q <= qtpu_pkg::PROB_HALF;
		end else if (upd_en) begin
			prob_q <= prob_nxt;
		end
	end

	assign prob = prob_q;

endmodule

`default_nettype wire

// File: hw/rtl/qtpu_track.sv
// ----------------------------------------------------------------------------
// qtpu_track: best and worst candidate tracker
// Compares each evaluated candidate against the global best and the worst
// of the current generation, and counts generations.
// ----------------------------------------------------------------------------
`default_nettype none

module qtpu_track (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               fire,
	input  wire qtpu_pkg::req_t                     req,
	output qtpu_pkg::track_t                        trk
);

	logic [qtpu_pkg::BITS_W-1:0]        best_bits_q;
	logic signed [qtpu_pkg::FIT_W-1:0]  best_fit_q;
	logic [qtpu_pkg::BITS_W-1:0]        worst_bits_q;
	logic signed [qtpu_pkg::FIT_W-1:0]  worst_fit_q;
	logic [qtpu_pkg::GEN_W-1:0]         gen_q;
	logic [qtpu_pkg::GEN_W-1:0]         best_gen_q;

	logic eval_en;
	logic end_en;
	logic better;
	logic worse;
	logic fit_neg;

	assign eval_en = fire && (req.func == qtpu_pkg::FUNC_EVAL);
	assign end_en  = fire && (req.func == qtpu_pkg::FUNC_END_GEN);
	assign better  = req.candidate_fitness > best_fit_q;
	assign worse   = req.candidate_fitness < worst_fit_q;
	assign fit_neg = req.candidate_fitness[qtpu_pkg::FIT_W-1];

	always_comb begin
		trk.best_bits_nxt  = best_bits_q;
		trk.best_score_nxt = best_fit_q;
		trk.best_round_nxt = best_gen_q;
		trk.improved       = 1'b0;
		if (eval_en && better) begin
			trk.best_bits_nxt  = fit_neg ? '0 : req.candidate_bits;
			trk.best_score_nxt = fit_neg ? '0 : req.candidate_fitness;
			trk.best_round_nxt = gen_q;
			trk.improved       = 1'b1;
		end
		trk.best_bits  = best_bits_q;
		trk.worst_bits = worst_bits_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_bits_q  <= '0;
			best_fit_q   <= '0;
			worst_bits_q <= '0;
			worst_fit_q  <= qtpu_pkg::FIT_MAX;
			gen_q        <= '0;
			best_gen_q   <= '0;
		end else begin
			if (eval_en) begin
				best_bits_q <= trk.best_bits_nxt;
				best_fit_q  <= trk.best_score_nxt;
				best_gen_q  <= trk.best_round_nxt;
				if (worse) begin
					worst_bits_q <= req.candidate_bits;
					worst_fit_q  <= req.candidate_fitness;
				end
			end
			if (end_en) begin
				worst_fit_q <= qtpu_pkg::FIT_MAX;
				gen_q       <= gen_q + 1'b1;
			end
		end
	end

	// The best fitness starts at zero and only rises, so it is never negative.
	a_best_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		!best_fit_q[qtpu_pkg::FIT_W-1])
		else $error("best fitness went negative");

	a_end_gen_worst: assert property (@(posedge clk) disable iff (!arst_n)
		end_en |=> (worst_fit_q == qtpu_pkg::FIT_MAX))
		else $error("worst fitness not restored at end of generation");

	a_end_gen_count: assert property (@(posedge clk) disable iff (!arst_n)
		end_en |=> (gen_q == $past(gen_q) + 1'b1))
		else $error("generation counter did not advance");

endmodule

`default_nettype wire

// File: hw/rtl/quantum_tabu_probability_update_unit.sv
// ----------------------------------------------------------------------------
// quantum_tabu_probability_update_unit: probability vector of a tabu search
// Top level with the probability lanes, the tracker, the sample merge and the
// result register.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on req_valid/req_ready with a req_t payload; each request
// produces exactly one response transaction on rsp_valid/rsp_ready.
// A request is executed in the cycle it is accepted: sampling reads one lane
// through the merge multiplexer, evaluation runs one 32-bit compare pair in
// the tracker, and end of generation updates every lane at once.
// The response is registered and appears in the cycle after acceptance. While
// rsp_ready is high, throughput is one transaction per cycle.
// The single response register decouples the sides: while a response waits
// on a stalled receiver, req_ready stays low unless rsp_ready is high.
// cfg_we writes the rotation step; users do so only when idle, unenforced.
// After reset every probability is one half, best and worst are cleared,
// the rotation step is 26 and no response is pending.
// ----------------------------------------------------------------------------
`default_nettype none

module quantum_tabu_probability_update_unit #(
	parameter int NUM_ITEMS = 32
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              req_valid,
	output logic                                   req_ready,
	input  wire qtpu_pkg::req_t                    req,
	output logic                                   rsp_valid,
	input  wire logic                              rsp_ready,
	output qtpu_pkg::rsp_t                         rsp,
	input  wire logic                              cfg_we,
	input  wire logic [qtpu_pkg::THETA_W-1:0]      cfg_wdata
);

	logic [qtpu_pkg::THETA_W-1:0] theta_q;
	logic                         rsp_valid_q;
	qtpu_pkg::rsp_t               rsp_q;
	qtpu_pkg::track_t             trk;
	logic                         fire;
	logic                         upd_en;
	logic                         sample_bit;
	logic [qtpu_pkg::PROB_W-1:0]  sel_prob;
	logic                         sel_hit;
	logic [qtpu_pkg::PROB_W-1:0]  prob [NUM_ITEMS];

	assign req_ready = !rsp_valid_q || rsp_ready;
	assign fire      = req_valid && req_ready;
	assign upd_en    = fire && (req.func == qtpu_pkg::FUNC_END_GEN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			theta_q <= qtpu_pkg::ROT_RESET;
		end else if (cfg_we) begin
			theta_q <= cfg_wdata;
		end
	end

	qtpu_track u_track (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.req    (req),
		.trk    (trk)
	);

	for (genvar i = 0; i < NUM_ITEMS; i++) begin : g_lane
		logic best_bit;
		logic worst_bit;
		if (i < qtpu_pkg::BITS_W) begin : g_bits
			assign best_bit  = trk.best_bits[i];
			assign worst_bit = trk.worst_bits[i];
		end else begin : g_zero
			assign best_bit  = 1'b0;
			assign worst_bit = 1'b0;
		end
		qtpu_lane u_lane (
			.clk       (clk),
			.arst_n    (arst_n),
			.upd_en    (upd_en),
			.theta     (theta_q),
			.best_bit  (best_bit),
			.worst_bit (worst_bit),
			.prob      (prob[i])
		);
	end

	always_comb begin
		sel_prob = '0;
		sel_hit  = 1'b0;
		for (int i = 0; i < NUM_ITEMS; i++) begin
			if (7'(req.item_index) == 7'(i)) begin
				sel_prob = prob[i];
				sel_hit  = 1'b1;
			end
		end
		sample_bit = (req.func == qtpu_pkg::FUNC_SAMPLE) && sel_hit &&
			(sel_prob > qtpu_pkg::PROB_W'(req.random_fraction));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fire) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_q.sample_bit <= sample_bit;
			rsp_q.best_bits  <= trk.best_bits_nxt;
			rsp_q.best_score <= trk.best_score_nxt;
			rsp_q.best_round <= trk.best_round_nxt;
			rsp_q.improved   <= trk.improved;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_improved_eval: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (req.func != qtpu_pkg::FUNC_EVAL) |=> !rsp.improved)
		else $error("improvement flagged on a non-evaluate transaction");

	a_sample_only: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (req.func != qtpu_pkg::FUNC_SAMPLE) |=> !rsp.sample_bit)
		else $error("sample bit set on a non-sample transaction");

	a_sample_range: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (req.func == qtpu_pkg::FUNC_SAMPLE) &&
		(7'(req.item_index) >= 7'(NUM_ITEMS)) |=> !rsp.sample_bit)
		else $error("sample bit set for an index beyond the table");

endmodule

`default_nettype wire

// File: bench/quantum_tabu_probability_update_unit_tb.sv
// ----------------------------------------------------------------------------
// quantum_tabu_probability_update_unit_tb: self-checking bench of the unit
// Every accepted request runs through a behavioral copy of the probability
// table, the best and worst tracker and the generation counter. The copy
// predicts the one response that the request must produce. A checker compares
// every response field by field with the oldest prediction. Directed tests
// cover the reset state, best and worst tracking, saturation of the rotation
// and the top fitness value. Random generations follow under several rotation
// steps, with gaps and stalls on both sides in all but one full-rate phase.
// ----------------------------------------------------------------------------
`default_nettype none

module quantum_tabu_probability_update_unit_tb;
	import qtpu_pkg::*;

	localparam int NUM_ITEMS    = 32;
	localparam int HALF_PERIOD  = 10;
	localparam int RESET_CYCLES = 8;
	localparam int PHASE_ITEMS  = 300;
	localparam int CYC_LIMIT    = 600000;
	localparam int MAX_REPORTS  = 60;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                req_valid = 1'b0;
	logic                req_ready;
	req_t                req       = '0;
	logic                rsp_valid;
	logic                rsp_ready = 1'b0;
	rsp_t                rsp;
	logic                cfg_we    = 1'b0;
	logic [THETA_W-1:0]  cfg_wdata = '0;

	logic [PROB_W-1:0]        prob_tbl [NUM_ITEMS];
	logic [BITS_W-1:0]        best_sol;
	logic [BITS_W-1:0]        worst_sol;
	logic signed [FIT_W-1:0]  best_fit;
	logic signed [FIT_W-1:0]  worst_fit;
	logic [GEN_W-1:0]         gen_count;
	logic [GEN_W-1:0]         best_gen;
	logic [THETA_W-1:0]       theta;

	rsp_t pending_rsp_q [$];
	int   err_cnt     = 0;
	int   checked_cnt = 0;
	int   cyc_cnt     = 0;
	int   n_sample    = 0;
	int   n_eval      = 0;
	int   n_improved  = 0;
	int   n_end_gen   = 0;
	int   n_nop       = 0;
	bit   idle_on     = 1'b1;
	int   stall_left  = 0;

	always #HALF_PERIOD clk = ~clk;

	quantum_tabu_probability_update_unit #(
		.NUM_ITEMS(NUM_ITEMS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// Applies one request to the behavioral state and returns its response.
	function automatic rsp_t update_search_state(req_t r);
		rsp_t                     o;
		int                       p;
		bit                       b;
		bit                       w;
		logic signed [FIT_W-1:0]  fit;
		o = '0;
		fit = $signed(r.candidate_fitness);
		case (r.func)
			FUNC_SAMPLE: begin
				if (r.item_index < NUM_ITEMS)
					o.sample_bit = (prob_tbl[r.item_index] > {1'b0, r.random_fraction});
			end
			FUNC_EVAL: begin
				if (fit > best_fit) begin
					if (fit >= 0) begin
						best_sol = r.candidate_bits;
						best_fit = fit;
					end else begin
						best_sol = '0;
						best_fit = '0;
					end
					best_gen = gen_count;
					o.improved = 1'b1;
				end
				if (worst_fit > fit) begin
					worst_sol = r.candidate_bits;
					worst_fit = fit;
				end
			end
			FUNC_END_GEN: begin
				for (int i = 0; i < NUM_ITEMS; i++) begin
					p = int'(prob_tbl[i]);
					b = (i < BITS_W) ? best_sol[i] : 1'b0;
					w = (i < BITS_W) ? worst_sol[i] : 1'b0;
					if (!b && w) begin
						if (p > PROB_HALF)
							p = PROB_ONE - p;
						p = (p > theta) ? p - theta : 0;
					end else if (b && !w) begin
						if (p < PROB_HALF)
							p = PROB_ONE - p;
						p = p + theta;
						if (p > PROB_ONE)
							p = PROB_ONE;
					end
					prob_tbl[i] = p[PROB_W-1:0];
				end
				worst_fit = FIT_MAX;
				gen_count = gen_count + 1'b1;
			end
			default: begin
			end
		endcase
		o.best_bits  = best_sol;
		o.best_score = best_fit;
		o.best_round = best_gen;
		return o;
	endfunction

	function automatic req_t make_req(func_t f, logic [4:0] idx, logic [15:0] frac,
			logic [BITS_W-1:0] cand, logic [FIT_W-1:0] fit);
		req_t r;
		r.func              = f;
		r.item_index        = idx;
		r.random_fraction   = frac;
		r.candidate_bits    = cand;
		r.candidate_fitness = fit;
		return r;
	endfunction

	function automatic logic [4:0] rnd_idx();
		return 5'($urandom);
	endfunction

	function automatic logic [15:0] rnd_frac();
		return 16'($urandom);
	endfunction

	function automatic int pick_gap();
		int r;
		if (!idle_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 20);
	endfunction

	task automatic send_req(input req_t r);
		int   gap;
		rsp_t want;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req       <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		want = update_search_state(r);
		pending_rsp_q.push_back(want);
		case (r.func)
			FUNC_SAMPLE:  n_sample++;
			FUNC_EVAL:    n_eval++;
			FUNC_END_GEN: n_end_gen++;
			default:      n_nop++;
		endcase
		if (want.improved)
			n_improved++;
	endtask

	task automatic wait_idle();
		@(negedge clk);
		req_valid <= 1'b0;
		while (pending_rsp_q.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic set_rotation_step(input logic [THETA_W-1:0] step);
		wait_idle();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= step;
		@(negedge clk);
		cfg_we <= 1'b0;
		theta = step;
	endtask

	task automatic test_reset_state();
		idle_on = 1'b1;
		send_req(make_req(FUNC_NOP, rnd_idx(), rnd_frac(), $urandom, $urandom));
		send_req(make_req(FUNC_SAMPLE, 5'd0, 16'd32767, $urandom, $urandom));
		send_req(make_req(FUNC_SAMPLE, 5'd31, 16'd32768, $urandom, $urandom));
		send_req(make_req(FUNC_SAMPLE, rnd_idx(), 16'd0, $urandom, $urandom));
	endtask

	task automatic test_best_and_worst();
		send_req(make_req(FUNC_EVAL, rnd_idx(), rnd_frac(),
			32'h0000_0000, 32'h8000_0000));
		send_req(make_req(FUNC_EVAL, rnd_idx(), rnd_frac(),
			32'hFFFF_FFFF, 32'h0000_0001));
		send_req(make_req(FUNC_EVAL, rnd_idx(), rnd_frac(),
			32'h1234_5678, 32'h0000_0001));
		send_req(make_req(FUNC_EVAL, rnd_idx(), rnd_frac(),
			32'hA5A5_A5A5, 32'hFFFF_FFFF));
	endtask

	// Drives every entry to the top, then to the bottom, then splits the table.
	task automatic test_rotation_saturation();
		set_rotation_step(12'd4095);
		repeat (9)
			send_req(make_req(FUNC_END_GEN, rnd_idx(), rnd_frac(), $urandom, $urandom));
		send_req(make_req(FUNC_SAMPLE, 5'd3, 16'hFFFF, $urandom, $urandom));
		send_req(make_req(FUNC_EVAL, rnd_idx(), rnd_frac(),
			32'h0000_0000, 32'h0000_0002));
		send_req(make_req(FUNC_EVAL, rnd_idx(), rnd_frac(),
			32'hFFFF_FFFF, 32'hFFFF_FFFB));
		send_req(make_req(FUNC_END_GEN, rnd_idx(), rnd_frac(), $urandom, $urandom));
		send_req(make_req(FUNC_SAMPLE, 5'd7, 16'd0, $urandom, $urandom));
		set_rotation_step(12'd0);
		send_req(make_req(FUNC_EVAL, rnd_idx(), rnd_frac(),
			32'h0000_FFFF, 32'h0000_0003));
		send_req(make_req(FUNC_EVAL, rnd_idx(), rnd_frac(),
			32'hFFFF_0000, 32'hFFFF_FFF9));
		send_req(make_req(FUNC_END_GEN, rnd_idx(), rnd_frac(), $urandom, $urandom));
		set_rotation_step(12'd1);
		send_req(make_req(FUNC_END_GEN, rnd_idx(), rnd_frac(), $urandom, $urandom));
		send_req(make_req(FUNC_SAMPLE, 5'd0, 16'hFFFF, $urandom, $urandom));
		send_req(make_req(FUNC_SAMPLE, 5'd31, 16'd0, $urandom, $urandom));
	endtask

	// Each generation evaluates a handful of candidates, mostly a little better
	// than the best so far, with samples and stray requests mixed in.
	task automatic test_random_generations(input int n_items, input logic [THETA_W-1:0] step,
			input bit idle);
		int                 sent;
		int                 n_cand;
		int                 pick;
		logic [FIT_W-1:0]   fit;
		set_rotation_step(step);
		idle_on = idle;
		sent = 0;
		while (sent < n_items) begin
			n_cand = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 10);
			for (int k = 0; k < n_cand; k++) begin
				if ($urandom_range(0, 2) == 0) begin
					send_req(make_req(FUNC_SAMPLE, rnd_idx(), rnd_frac(),
						$urandom, $urandom));
					sent++;
				end
				if ($urandom_range(0, 19) == 0) begin
					send_req(make_req(func_t'($urandom_range(0, 3)), rnd_idx(),
						rnd_frac(), $urandom, $urandom));
					sent++;
				end
				pick = $urandom_range(0, 99);
				if (pick < 60) begin
					if (best_fit > FIT_MAX - 32'sd65536)
						fit = $urandom;
					else
						fit = best_fit + 32'($urandom_range(1, 65536));
				end else if (pick < 85) begin
					fit = best_fit - 32'($urandom_range(0, 1 << 20));
				end else if (pick < 93) begin
					fit = $urandom;
				end else begin
					fit = 32'h8000_0000 | 32'($urandom);
				end
				send_req(make_req(FUNC_EVAL, rnd_idx(), rnd_frac(), $urandom, fit));
				sent++;
			end
			send_req(make_req(FUNC_END_GEN, rnd_idx(), rnd_frac(), $urandom, $urandom));
			sent++;
		end
	endtask

	// The top fitness becomes the best, and neither it nor a repeat of it
	// becomes the worst.
	task automatic test_top_fitness();
		idle_on = 1'b1;
		send_req(make_req(FUNC_EVAL, rnd_idx(), rnd_frac(), $urandom, FIT_MAX));
		send_req(make_req(FUNC_EVAL, rnd_idx(), rnd_frac(), $urandom, FIT_MAX));
		send_req(make_req(FUNC_END_GEN, rnd_idx(), rnd_frac(), $urandom, $urandom));
		send_req(make_req(FUNC_SAMPLE, rnd_idx(), rnd_frac(), $urandom, $urandom));
	endtask

	always @(negedge clk) begin
		if (!idle_on) begin
			rsp_ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			rsp_ready <= 1'b0;
		end else begin
			case ($urandom_range(0, 99)) inside
				[0:59]:  rsp_ready <= 1'b1;
				[60:91]: begin
					rsp_ready <= 1'b0;
					stall_left = $urandom_range(0, 2);
				end
				default: begin
					rsp_ready <= 1'b0;
					stall_left = $urandom_range(5, 30);
				end
			endcase
		end
	end

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_rsp_q.size() == 0) begin
				err_cnt++;
				if (err_cnt <= MAX_REPORTS)
					$display("%0t: unexpected response, expected none, got %h", $time, rsp);
			end else begin
				want = pending_rsp_q.pop_front();
				checked_cnt++;
				if (rsp.sample_bit !== want.sample_bit) begin
					err_cnt++;
					if (err_cnt <= MAX_REPORTS)
						$display("%0t: sample_bit expected %b, got %b", $time,
							want.sample_bit, rsp.sample_bit);
				end
				if (rsp.best_bits !== want.best_bits) begin
					err_cnt++;
					if (err_cnt <= MAX_REPORTS)
						$display("%0t: best_bits expected %h, got %h", $time,
							want.best_bits, rsp.best_bits);
				end
				if (rsp.best_score !== want.best_score) begin
					err_cnt++;
					if (err_cnt <= MAX_REPORTS)
						$display("%0t: best_score expected %h, got %h", $time,
							want.best_score, rsp.best_score);
				end
				if (rsp.best_round !== want.best_round) begin
					err_cnt++;
					if (err_cnt <= MAX_REPORTS)
						$display("%0t: best_round expected %0d, got %0d", $time,
							want.best_round, rsp.best_round);
				end
				if (rsp.improved !== want.improved) begin
					err_cnt++;
					if (err_cnt <= MAX_REPORTS)
						$display("%0t: improved expected %b, got %b", $time,
							want.improved, rsp.improved);
				end
			end
		end
	end

	always @(posedge clk) begin
		cyc_cnt++;
		if (cyc_cnt == CYC_LIMIT) begin
			$display("%0t: timeout with %0d responses outstanding", $time,
				pending_rsp_q.size());
			$display("quantum_tabu_probability_update_unit_tb: done, errors");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < NUM_ITEMS; i++)
			prob_tbl[i] = PROB_HALF;
		best_sol  = '0;
		best_fit  = '0;
		worst_sol = '0;
		worst_fit = FIT_MAX;
		gen_count = '0;
		best_gen  = '0;
		theta     = ROT_RESET;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;

		test_reset_state();
		test_best_and_worst();
		test_rotation_saturation();
		test_random_generations(PHASE_ITEMS, 12'($urandom_range(0, 4095)), 1'b1);
		test_random_generations(PHASE_ITEMS, 12'd4095, 1'b0);
		test_random_generations(PHASE_ITEMS, 12'($urandom_range(1, 64)), 1'b1);
		test_top_fitness();
		wait_idle();
		repeat (5) @(posedge clk);

		$display("Checked %0d responses: %0d samples, %0d evaluations (%0d improved the best),",
			checked_cnt, n_sample, n_eval, n_improved);
		$display("%0d generation updates and %0d no-op requests, under several rotation steps.",
			n_end_gen, n_nop);
		if (err_cnt == 0) begin
			$display("quantum_tabu_probability_update_unit_tb: done, clean");
		end else begin
			$display("quantum_tabu_probability_update_unit_tb: done, errors");
		end
		$finish;
	end

endmodule

`default_nettype wire

// File: sim.f
hw/rtl/qtpu_pkg.sv
hw/rtl/qtpu_lane.sv
hw/rtl/qtpu_track.sv
hw/rtl/quantum_tabu_probability_update_unit.sv
bench/quantum_tabu_probability_update_unit_tb.sv
